@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the volume scaler.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge outside reset.
`define AVS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// A condition that must hold in the same cycle as its trigger.
`define AVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// A condition that must hold in the cycle after its trigger.
`define AVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AVS_ASSERT(label, clk, rst_n, expr)
`define AVS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/avs_pkg.sv @@
// Types, constants and helper functions of the audio volume scaler.
// Depends on nothing; used by audio_volume_scaler_unit.
`timescale 1ns / 1ps

package avs_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTED  = 4'd2;

    // Sample format codes.
    localparam logic [1:0] FMT_FLOAT32 = 2'd0;
    localparam logic [1:0] FMT_PCM16   = 2'd1;
    localparam logic [1:0] FMT_PCM24   = 2'd2;
    localparam logic [1:0] FMT_PCM32   = 2'd3;

    // Gain constants in unsigned Q16.
    localparam int unsigned VOL_W = 18;
    localparam logic [VOL_W-1:0] VOL_RESET  = 18'd65536;
    localparam logic [VOL_W-1:0] VOL_MAX    = 18'd131072;
    localparam logic [VOL_W-1:0] VOL_EPS    = 18'd6;
    localparam logic [VOL_W-1:0] VOL_PASS_LO = 18'd65530;
    localparam logic [VOL_W-1:0] VOL_PASS_HI = 18'd65542;

    // Datapath widths.
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PROD_W  = WORD_W + VOL_W;
    localparam int unsigned FPROD_W = 42;
    localparam logic [WORD_W-1:0] FLOAT_ONE = 32'h3F80_0000;

    // Control carried alongside the data through every stage.
    typedef struct packed {
        logic              silent;
        logic              pass;
        logic [1:0]        fmt;
        logic [WORD_W-1:0] pass_word;
        logic              neg;
        logic              sign;
        logic [7:0]        exp;
        logic              nonfinite;
    } ctrl_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [WORD_W-1:0] op;
    } stage_a_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic [PROD_W-1:0] prod;
    } stage_b_t;

    typedef struct packed {
        ctrl_t              ctrl;
        logic [FPROD_W-1:0] prod;
        logic               prod_zero;
        logic [5:0]         lead;
        logic [WORD_W-1:0]  pcm_q;
    } stage_c_t;

    typedef struct packed {
        ctrl_t             ctrl;
        logic              prod_zero;
        logic              clamp_one;
        logic [7:0]        expf;
        logic [24:0]       mant;
        logic              rnd;
        logic [WORD_W-1:0] pcm_res;
    } stage_d_t;

    // Mask of the bits that a format uses.
    function automatic logic [WORD_W-1:0] fmt_mask(input logic [1:0] fmt);
        logic [WORD_W-1:0] m;
        unique case (fmt)
            FMT_PCM16: m = 32'h0000_FFFF;
            FMT_PCM24: m = 32'h00FF_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Sign bit of a PCM format.
    function automatic logic [WORD_W-1:0] fmt_signbit(input logic [1:0] fmt);
        logic [WORD_W-1:0] b;
        unique case (fmt)
            FMT_PCM16: b = 32'h0000_8000;
            FMT_PCM24: b = 32'h0080_0000;
            default:   b = 32'h8000_0000;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/audio_volume_scaler_unit.sv @@
// Top level of the audio volume scaler: configuration registers and a
// five-stage gain pipeline. Depends on avs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Digital volume stage. One sample item is taken on every cycle that start is
// high (busy is always low) and its result appears on scaled_bits and
// is_silent after the five register stages, marked by done for a single cycle.
// Throughput is one item per cycle. The five register stages are input
// decode, the 32 x 18 bit gain multiplier, leading-one search and PCM
// rounding, float alignment, and final rounding and packing. The
// receiver cannot hold results off, so results must be taken as they appear.
// Configuration writes are always accepted (cfg_ready is high) and must only
// be made while no item is in flight.
module audio_volume_scaler_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [avs_pkg::WORD_W-1:0]        sample_bits,
    input  logic                              packet_silent,
    output logic                              done,
    output logic [avs_pkg::WORD_W-1:0]        scaled_bits,
    output logic                              is_silent,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [avs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [avs_pkg::VOL_W-1:0]         cfg_data
);
    import avs_pkg::*;

    logic [1:0]       fmt_reg;
    logic [VOL_W-1:0] vol_reg;
    logic             muted_reg;
    logic [VOL_W-1:0] vol_next;

    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg;
    stage_a_t a_reg, a_next;
    stage_b_t b_reg, b_next;
    stage_c_t c_reg, c_next;
    stage_d_t d_reg, d_next;
    logic [WORD_W-1:0] e_data_reg, e_data_next;
    logic              e_sil_reg;

    logic accept;

    // Output qualifiers used by the checks below.
    logic out_pcm16;
    logic out_float_scaled;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers; the gain saturates at 2.0.
    assign vol_next = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_PCM16;
            vol_reg   <= VOL_RESET;
            muted_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FORMAT)
            begin
                fmt_reg <= cfg_data[1:0];
            end
            if (cfg_index == CFG_VOLUME)
            begin
                vol_reg <= vol_next;
            end
            if (cfg_index == CFG_MUTED)
            begin
                muted_reg <= cfg_data[0];
            end
        end
    end

    // Stage A: decide silence and pass-through, unpack the sample.
    always_comb
    begin
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] raw;
        logic [WORD_W-1:0] mag;
        logic [7:0]        ex;
        mask = fmt_mask(fmt_reg);
        raw  = sample_bits & mask;
        ex   = sample_bits[30:23];
        a_next.ctrl.silent    = packet_silent || muted_reg || (vol_reg <= VOL_EPS);
        a_next.ctrl.pass      = (vol_reg >= VOL_PASS_LO) && (vol_reg <= VOL_PASS_HI);
        a_next.ctrl.fmt       = fmt_reg;
        a_next.ctrl.pass_word = raw;
        a_next.ctrl.neg       = (raw & fmt_signbit(fmt_reg)) != '0;
        a_next.ctrl.sign      = sample_bits[31];
        a_next.ctrl.exp       = (ex == 8'd0) ? 8'd1 : ex;
        a_next.ctrl.nonfinite = (ex == 8'hFF);
        mag = a_next.ctrl.neg ? ((32'd0 - raw) & mask) : raw;
        if (fmt_reg == FMT_FLOAT32)
        begin
            a_next.op = {8'd0, (ex != 8'd0), sample_bits[22:0]};
        end
        else
        begin
            a_next.op = mag;
        end
    end

    // Stage B: the gain multiplier, shared by both sample kinds.
    always_comb
    begin
        b_next.ctrl = a_reg.ctrl;
        b_next.prod = a_reg.op * vol_reg;
    end

    // Stage C: leading-one search for float, rounding and saturation for PCM.
    always_comb
    begin
        logic [PROD_W:0]   qsum;
        logic [WORD_W+2:0] q;
        logic [WORD_W-1:0] lim;
        qsum = {1'b0, b_reg.prod} + (PROD_W+1)'(32768);
        q    = qsum[PROD_W:16];
        lim  = b_reg.ctrl.neg ? fmt_signbit(b_reg.ctrl.fmt)
                              : (fmt_signbit(b_reg.ctrl.fmt) - 32'd1);
        c_next.ctrl      = b_reg.ctrl;
        c_next.prod      = b_reg.prod[FPROD_W-1:0];
        c_next.prod_zero = (b_reg.prod[FPROD_W-1:0] == '0);
        c_next.lead      = 6'd0;
        for (int i = 0; i < FPROD_W; i++)
        begin
            if (b_reg.prod[i])
            begin
                c_next.lead = 6'(i);
            end
        end
        c_next.pcm_q = (q > {3'd0, lim}) ? lim : q[WORD_W-1:0];
    end

    // Stage D: align the float mantissa, negate the PCM result.
    always_comb
    begin
        logic signed [9:0]  e2;
        logic signed [9:0]  x;
        logic signed [9:0]  q;
        logic signed [9:0]  qc;
        logic signed [9:0]  s;
        logic [4:0]         sh;
        logic [FPROD_W-1:0] shifted;
        logic [FPROD_W-1:0] below;
        logic               guard;
        logic               sticky;
        e2 = $signed({2'd0, c_reg.ctrl.exp}) - 10'sd166;
        x  = $signed({4'd0, c_reg.lead}) + e2;
        q  = x - 10'sd23;
        qc = (q < -10'sd149) ? -10'sd149 : q;
        s  = qc - e2;
        shifted = '0;
        below   = '0;
        guard   = 1'b0;
        sticky  = 1'b0;
        d_next.ctrl      = c_reg.ctrl;
        d_next.prod_zero = c_reg.prod_zero;
        d_next.clamp_one = (x >= 10'sd0);
        d_next.expf      = 8'(qc + 10'sd149);
        if (s <= 10'sd0)
        begin
            sh          = 5'(-s);
            d_next.mant = c_reg.prod[24:0] << sh;
            d_next.rnd  = 1'b0;
        end
        else
        begin
            sh          = 5'(s);
            shifted     = c_reg.prod >> sh;
            below       = c_reg.prod >> (sh - 5'd1);
            guard       = below[0];
            sticky      = (c_reg.prod & ((FPROD_W'(1) << (sh - 5'd1)) - FPROD_W'(1))) != '0;
            d_next.mant = shifted[24:0];
            d_next.rnd  = guard && (sticky || shifted[0]);
        end
        d_next.pcm_res = c_reg.ctrl.neg ? (32'd0 - c_reg.pcm_q) : c_reg.pcm_q;
    end

    // Stage E: round to nearest even, pack and pick the output word.
    always_comb
    begin
        logic [24:0]       mant;
        logic [WORD_W-1:0] fword;
        mant  = d_reg.mant + {24'd0, d_reg.rnd};
        fword = {d_reg.ctrl.sign, 31'd0}
              | ({1'b0, d_reg.expf, 23'd0} + {7'd0, mant});
        if (d_reg.ctrl.silent)
        begin
            e_data_next = '0;
        end
        else if (d_reg.ctrl.pass)
        begin
            e_data_next = d_reg.ctrl.pass_word;
        end
        else if (d_reg.ctrl.fmt == FMT_FLOAT32)
        begin
            priority if (d_reg.ctrl.nonfinite)
            begin
                e_data_next = '0;
            end
            else if (d_reg.prod_zero)
            begin
                e_data_next = {d_reg.ctrl.sign, 31'd0};
            end
            else if (d_reg.clamp_one)
            begin
                e_data_next = {d_reg.ctrl.sign, 31'd0} | FLOAT_ONE;
            end
            else
            begin
                e_data_next = fword;
            end
        end
        else
        begin
            e_data_next = d_reg.pcm_res & fmt_mask(d_reg.ctrl.fmt);
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        e_data_reg <= e_data_next;
        e_sil_reg  <= d_reg.ctrl.silent;
    end

    assign done        = e_vld_reg;
    assign scaled_bits = e_data_reg;
    assign is_silent   = e_sil_reg;

    // A pcm16 result, and a float result that went through the multiplier.
    assign out_pcm16        = done && (fmt_reg == FMT_PCM16);
    assign out_float_scaled = done && !is_silent && (fmt_reg == FMT_FLOAT32)
                            && !((vol_reg >= VOL_PASS_LO) && (vol_reg <= VOL_PASS_HI));

    // A silent item always carries a zero word.
    `AVS_ASSERT_IMPL(a_silent_zero, clk, rst_n, done && is_silent, scaled_bits == '0)
    // Pcm16 results never set bits above the sample width.
    `AVS_ASSERT_IMPL(a_pcm16_upper, clk, rst_n, out_pcm16, scaled_bits[31:16] == 16'd0)
    // A scaled float never exceeds 1.0 in magnitude.
    `AVS_ASSERT_IMPL(a_float_clamp, clk, rst_n, out_float_scaled, scaled_bits[30:0] <= FLOAT_ONE[30:0])
    // The stored gain stays within 0 to 2.0.
    `AVS_ASSERT(a_vol_range, clk, rst_n, vol_reg <= VOL_MAX)
    // An item in stage D always reaches the output in the next cycle.
    `AVS_ASSERT_NEXT(a_out_follows, clk, rst_n, d_vld_reg, done)

endmodule

@@ dv/avs_gain_checker.sv @@
// Checker for the audio volume scaler: predicts each scaled sample and compares it.
// Depends on avs_pkg. The testbench top instantiates it beside the scaler.
`timescale 1ns / 1ps

module avs_gain_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [avs_pkg::WORD_W-1:0]    sample_bits,
    input  logic                          packet_silent,
    input  logic                          done,
    input  logic [avs_pkg::WORD_W-1:0]    scaled_bits,
    input  logic                          is_silent,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [avs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [avs_pkg::VOL_W-1:0]     cfg_data,
    output int unsigned                   fail_count,
    output int unsigned                   outstanding
);
    import avs_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] bits;
        logic              silent;
    } scaled_sample_t;

    // Mirror of the configuration registers.
    logic [1:0]       fmt_cfg  = FMT_PCM16;
    logic [VOL_W-1:0] gain_cfg = VOL_RESET;
    logic             mute_cfg = 1'b0;

    // Scaled samples still to come out, oldest first.
    scaled_sample_t pending_samples[$];

    // Gain of a two's complement PCM sample, rounded half away from zero
    // and saturated to the sample width.
    function automatic logic [WORD_W-1:0] pcm_gain(input logic [WORD_W-1:0] word,
                                                   input int width,
                                                   input logic [VOL_W-1:0] gain);
        logic [63:0] mask;
        logic [63:0] sbit;
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        mask = (64'd1 << width) - 64'd1;
        sbit = 64'd1 << (width - 1);
        raw  = {32'd0, word} & mask;
        neg  = |(raw & sbit);
        mag  = neg ? ((-raw) & mask) : raw;
        if (neg && mag == 64'd0)
            mag = sbit;
        q = (mag * {46'd0, gain} + 64'd32768) >> 16;
        if (neg)
        begin
            if (q > sbit)
                q = sbit;
            return WORD_W'((-q) & mask);
        end
        if (q > sbit - 64'd1)
            q = sbit - 64'd1;
        return q[WORD_W-1:0];
    endfunction

    // Gain of a binary32 sample: exact product, round to nearest even,
    // clamp to one, non-finite inputs give positive zero.
    function automatic logic [WORD_W-1:0] float_gain(input logic [WORD_W-1:0] word,
                                                     input logic [VOL_W-1:0] gain);
        logic [WORD_W-1:0] sign_w;
        logic [63:0]       frac;
        logic [63:0]       prod;
        logic [63:0]       mant;
        logic [63:0]       rem;
        logic [63:0]       half;
        int                ex;
        int                e2;
        int                msb;
        int                x;
        int                q;
        int                s;
        sign_w = word & 32'h8000_0000;
        ex     = int'(word[30:23]);
        frac   = {41'd0, word[22:0]};
        if (ex == 255)
            return '0;
        if (ex == 0)
            ex = 1;
        else
            frac[23] = 1'b1;
        prod = frac * {46'd0, gain};
        if (prod == 64'd0)
            return sign_w;
        // The value is prod times two to the power e2.
        e2  = ex - 166;
        msb = 0;
        for (int i = 0; i < 64; i++)
            if (prod[i])
                msb = i;
        x = msb + e2;
        if (x >= 0)
            return sign_w | FLOAT_ONE;
        q = x - 23;
        if (q < -149)
            q = -149;
        s = q - e2;
        if (s <= 0)
            mant = prod << (-s);
        else if (s >= 64)
            mant = 64'd0;
        else
        begin
            rem  = prod & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            mant = prod >> s;
            if (rem > half || (rem == half && mant[0]))
                mant = mant + 64'd1;
        end
        // A carry out of the mantissa rolls into the exponent on its own.
        return sign_w | WORD_W'((64'(q + 149) << 23) + mant);
    endfunction

    // Expected output for one sample item under the current settings.
    function automatic scaled_sample_t predict_scaled(input logic [WORD_W-1:0] word,
                                                      input logic pkt_silent);
        scaled_sample_t    res;
        int                width;
        logic [WORD_W-1:0] wmask;
        width = (fmt_cfg == FMT_PCM16) ? 16 : ((fmt_cfg == FMT_PCM24) ? 24 : 32);
        wmask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        res   = '0;
        if (pkt_silent || mute_cfg || gain_cfg <= VOL_EPS)
        begin
            res.silent = 1'b1;
            return res;
        end
        if (gain_cfg + VOL_EPS >= VOL_RESET && gain_cfg <= VOL_RESET + VOL_EPS)
            res.bits = word & wmask;
        else if (fmt_cfg == FMT_FLOAT32)
            res.bits = float_gain(word, gain_cfg) & wmask;
        else
            res.bits = pcm_gain(word, width, gain_cfg) & wmask;
        return res;
    endfunction

    // Watch the three channels at every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        scaled_sample_t want;
        if (!rst_n)
        begin
            fmt_cfg  = FMT_PCM16;
            gain_cfg = VOL_RESET;
            mute_cfg = 1'b0;
            pending_samples.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare each result with the oldest expectation.
            if (done)
            begin
                if (pending_samples.size() == 0)
                begin
                    $error("result with no item outstanding: scaled_bits %h is_silent %b",
                           scaled_bits, is_silent);
                    fail_count++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (scaled_bits !== want.bits)
                    begin
                        $error("scaled_bits: expected %h, actual %h", want.bits, scaled_bits);
                        fail_count++;
                    end
                    if (is_silent !== want.silent)
                    begin
                        $error("is_silent: expected %b, actual %b", want.silent, is_silent);
                        fail_count++;
                    end
                end
            end

            // An accepted item uses the settings in force before this edge.
            if (start && !busy)
                pending_samples.push_back(predict_scaled(sample_bits, packet_silent));

            // Register writes; volume writes saturate at two.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORMAT: fmt_cfg = cfg_data[1:0];
                    CFG_VOLUME: gain_cfg = (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
                    CFG_MUTED:  mute_cfg = cfg_data[0];
                    default: ;
                endcase
            end

            outstanding <= pending_samples.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Testbench top for audio_volume_scaler_unit: clock, reset, stimulus and verdict.
// Depends on avs_pkg, the scaler RTL and avs_gain_checker.
`timescale 1ns / 1ps

module testbench;
    import avs_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 1000;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic [WORD_W-1:0] sample_bits   = '0;
    logic              packet_silent = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [VOL_W-1:0]  cfg_data      = '0;
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] scaled_bits;
    logic              is_silent;
    logic              cfg_ready;
    int unsigned       fail_count;
    int unsigned       outstanding;

    // Gaps between items are switched off for some phases.
    logic              no_gaps = 1'b0;
    int                stall_cycles = 0;

    audio_volume_scaler_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample_bits   (sample_bits),
        .packet_silent (packet_silent),
        .done          (done),
        .scaled_bits   (scaled_bits),
        .is_silent     (is_silent),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    avs_gain_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample_bits   (sample_bits),
        .packet_silent (packet_silent),
        .done          (done),
        .scaled_bits   (scaled_bits),
        .is_silent     (is_silent),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // 10 ns clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // End the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Present one sample item after a random gap and hold it until taken.
    task automatic send_sample(input logic [WORD_W-1:0] word, input logic pkt_silent);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        sample_bits   <= word;
        packet_silent <= pkt_silent;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and wait until every scaled sample has come out.
    task automatic drain_samples();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Register write, made only once the pipeline is empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOL_W-1:0] value);
        drain_samples();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gain(input logic [1:0] fmt, input logic [VOL_W-1:0] gain,
                            input logic mute);
        write_reg(CFG_FORMAT, {16'd0, fmt});
        write_reg(CFG_VOLUME, gain);
        write_reg(CFG_MUTED, {17'd0, mute});
    endtask

    // Gains weighted towards the silent threshold, the pass band and the top.
    function automatic logic [VOL_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return VOL_W'($urandom_range(0, 7));
            1: return VOL_W'($urandom_range(7, 300));
            2: return VOL_W'($urandom_range(65522, 65550));
            3: return VOL_MAX;
            4: return VOL_W'($urandom_range(131073, 262143));
            5: return VOL_W'($urandom_range(60000, 70000));
            default: return VOL_W'($urandom_range(7, 131072));
        endcase
    endfunction

    // Sample words shaped to the format: boundary values for PCM, and
    // exponents near one, subnormals and non-finite values for float.
    function automatic logic [WORD_W-1:0] pick_sample(input logic [1:0] fmt);
        logic [WORD_W-1:0] word;
        logic [7:0]        ex;
        logic [WORD_W-1:0] sbit;
        word = $urandom;
        if (fmt == FMT_FLOAT32)
        begin
            case ($urandom_range(0, 9))
                0: ex = 8'd0;
                1: ex = 8'd255;
                2: ex = 8'($urandom_range(0, 30));
                3, 4, 5, 6: ex = 8'($urandom_range(100, 127));
                default: ex = 8'($urandom);
            endcase
            word[30:23] = ex;
            if ($urandom_range(0, 9) == 0)
                word[22:0] = ($urandom_range(0, 1) == 0) ? 23'd0 : 23'h7F_FFFF;
            return word;
        end
        sbit = (fmt == FMT_PCM16) ? 32'h0000_8000 :
               ((fmt == FMT_PCM24) ? 32'h0080_0000 : 32'h8000_0000);
        case ($urandom_range(0, 9))
            0: word = (word & ~((sbit << 1) - 32'd1)) | sbit;
            1: word = (word & ~((sbit << 1) - 32'd1)) | (sbit - 32'd1);
            2: word = word | ((sbit << 1) - 32'd1);
            3: word = word & ~((sbit << 1) - 32'd1);
            default: ;
        endcase
        return word;
    endfunction

    // Main sequence: reset, directed cases, random phases, verdict.
    initial
    begin : stimulus
        int sent;
        int phase_len;
        logic [1:0] fmt;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: pcm16 at unity passes the low half through.
        send_sample(32'h1234_8000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);

        // pcm16 at full gain saturates both ways.
        set_gain(FMT_PCM16, VOL_MAX, 1'b0);
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'hABCD_8000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);

        // pcm24 at half gain: rounding half away from zero.
        set_gain(FMT_PCM24, 18'd32768, 1'b0);
        send_sample(32'h0080_0000, 1'b0);
        send_sample(32'hFF7F_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h00FF_FFFF, 1'b0);

        // pcm32 at full gain.
        set_gain(FMT_PCM32, VOL_MAX, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);

        // Float at full gain: clamp, infinity, NaN, signed zero, subnormal.
        set_gain(FMT_FLOAT32, VOL_MAX, 1'b0);
        send_sample(32'h3F00_0000, 1'b0);
        send_sample(32'h7F80_0000, 1'b0);
        send_sample(32'h7FC0_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hFF7F_FFFF, 1'b0);

        // Float at a tiny gain rounds towards the subnormals.
        set_gain(FMT_FLOAT32, 18'd7, 1'b0);
        send_sample(32'h0080_0001, 1'b0);

        // Gain at the silent threshold, then mute.
        set_gain(FMT_FLOAT32, VOL_EPS, 1'b0);
        send_sample(32'h3F80_0000, 1'b0);
        set_gain(FMT_PCM16, 18'd0, 1'b1);
        send_sample(32'h0000_1234, 1'b0);

        // Float near unity passes even a NaN through.
        set_gain(FMT_FLOAT32, VOL_PASS_HI, 1'b0);
        send_sample(32'h7FC0_0001, 1'b0);

        // An oversized volume write saturates at two.
        set_gain(FMT_PCM16, 18'h3FFFF, 1'b0);
        send_sample(32'h0000_4001, 1'b0);

        // Random phases, each under a fresh set of registers.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            fmt = 2'($urandom_range(0, 3));
            set_gain(fmt, pick_gain(), $urandom_range(0, 11) == 0);
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 150);
            repeat (phase_len)
            begin
                send_sample(pick_sample(fmt), $urandom_range(0, 9) == 0);
                sent++;
            end
            no_gaps = 1'b0;
        end

        // Let the pipeline empty and give stray results a chance to show.
        drain_samples();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
